@@ rtl/cas_pkg.sv @@
package cas_pkg;

  localparam int WFRAC = 14;
  localparam int QW    = 17;

  localparam logic [1:0] REG_NUM_CHANNELS = 2'd0;
  localparam logic [1:0] REG_MAP_WIDTH    = 2'd1;
  localparam logic [1:0] REG_MAP_HEIGHT   = 2'd2;

  typedef enum logic [6:0] {
    S_LOAD    = 7'b0000001,
    S_CHECK   = 7'b0000010,
    S_RDSUM   = 7'b0000100,
    S_DIVGO   = 7'b0001000,
    S_DIVWAIT = 7'b0010000,
    S_DRAIN   = 7'b0100000,
    S_MUL     = 7'b1000000
  } state_t;

  typedef struct packed {
    logic load;
    logic restart;
    logic set_zero;
    logic clr_zero;
    logic sum_rd;
    logic div_start;
    logic w_wr;
    logic wch_clr;
    logic wch_inc;
    logic rd_issue;
    logic mul;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic pos_last;
    logic total_zero;
    logic wch_last;
    logic div_done;
  } sts_t;

endpackage

@@ rtl/channel_attention_scaler.sv @@
// Channel attention scaler.
// A command is taken when start is high and busy is low; op 0 loads one Q8.8
// sample, op 1 asks for the next scaled sample. Samples arrive channel by
// channel, row by row. Busy stays low through the loads. After the last load
// the block is busy while it forms one Q2.14 weight per channel (channel sum
// over total), one channel after another through the shared restoring
// divider, or skips the divider when the total is zero.
// A read keeps busy high after it is taken (memory read at the taking edge,
// multiply, round); result_valid pulses for one cycle in the cycle busy
// drops, with scaled, channel, zero_total and last. The receiver cannot
// stall, so each beat must be taken when shown.
// Loads while draining and reads while loading are accepted and dropped.
// Configuration writes (cfg_valid, always ready) restart the map and should be
// issued only while idle. Reset sets all sizes to one and enters the load
// phase; the sample store holds nothing until loaded and needs no clearing.
module channel_attention_scaler #(
  parameter int MAX_CHANNELS = 64,
  parameter int MAX_SIDE     = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               op,
  input  logic signed [15:0] sample,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [6:0]         cfg_data,
  output logic               result_valid,
  output logic signed [15:0] scaled,
  output logic [5:0]         channel,
  output logic               zero_total,
  output logic               last
);

  cas_pkg::cmd_t cmd;
  cas_pkg::sts_t sts;
  logic          cfg_fire;
  logic          cfg_write;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  // Only a beat that names an existing register restarts the map.
  assign cfg_write = cfg_fire && (cfg_index == cas_pkg::REG_NUM_CHANNELS ||
                                  cfg_index == cas_pkg::REG_MAP_WIDTH ||
                                  cfg_index == cas_pkg::REG_MAP_HEIGHT);

  cas_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .op       (op),
    .cfg_fire (cfg_write),
    .sts      (sts),
    .cmd      (cmd),
    .busy     (busy)
  );

  cas_dp #(
    .MAX_CHANNELS(MAX_CHANNELS),
    .MAX_SIDE    (MAX_SIDE)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_fire     (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample       (sample),
    .scaled       (scaled),
    .channel      (channel),
    .zero_total   (zero_total),
    .last         (last),
    .result_valid (result_valid)
  );

endmodule

@@ rtl/cas_div.sv @@
module cas_div #(
  parameter int NUM_W = 41,
  parameter int DEN_W = 33
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [NUM_W-1:0]        num,
  input  logic [DEN_W-1:0]        den,
  input  logic                    neg,
  output logic                    done,
  output logic signed [15:0]      quot
);

  localparam int QW = cas_pkg::QW;
  localparam int RW = ((NUM_W + 1 > DEN_W + QW) ? NUM_W + 1 : DEN_W + QW) + 1;

  logic [RW-1:0] rem;
  logic [RW-1:0] dsh;
  logic [QW-1:0] q;
  logic [4:0]    cnt;
  logic          running;
  logic          ovf;
  logic          negr;
  logic [RW-1:0] n_init;

  // Adding half the divisor first gives rounding to nearest, ties away from zero.
  assign n_init = RW'(num) + RW'(den >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= 5'(QW);
      end else if (running) begin
        if (cnt == 5'd0) begin
          running <= 1'b0;
          done    <= 1'b1;
        end else begin
          cnt <= cnt - 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= n_init;
      dsh  <= RW'(den) << (QW - 1);
      ovf  <= n_init >= (RW'(den) << QW);
      negr <= neg;
      q    <= '0;
    end else if (running && cnt != 5'd0) begin
      if (rem >= dsh) begin
        rem <= rem - dsh;
        q   <= {q[QW-2:0], 1'b1};
      end else begin
        q   <= {q[QW-2:0], 1'b0};
      end
      dsh <= dsh >> 1;
    end
    if (running && cnt == 5'd0) begin
      if (negr) begin
        if (ovf || q > QW'(32768)) quot <= 16'sh8000;
        else quot <= 16'(-q);
      end else begin
        if (ovf || q > QW'(32767)) quot <= 16'sh7fff;
        else quot <= q[15:0];
      end
    end
  end

endmodule

@@ rtl/cas_dp.sv @@
module cas_dp #(
  parameter int MAX_CHANNELS = 64,
  parameter int MAX_SIDE     = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  cas_pkg::cmd_t       cmd,
  output cas_pkg::sts_t       sts,
  input  logic                cfg_fire,
  input  logic [1:0]          cfg_index,
  input  logic [6:0]          cfg_data,
  input  logic signed [15:0]  sample,
  output logic signed [15:0]  scaled,
  output logic [5:0]          channel,
  output logic                zero_total,
  output logic                last,
  output logic                result_valid
);

  localparam int DEPTH = MAX_CHANNELS * MAX_SIDE * MAX_SIDE;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int CHW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int SDW   = $clog2(MAX_SIDE + 1);
  localparam int CNW   = $clog2(MAX_CHANNELS + 1);
  localparam int SW    = 16 + $clog2(MAX_SIDE * MAX_SIDE) + 1;
  localparam int TW    = SW + $clog2(MAX_CHANNELS);
  localparam int NUM_W = SW + cas_pkg::WFRAC;

  logic [6:0] reg_nc;
  logic [5:0] reg_w;
  logic [5:0] reg_h;
  logic [CNW-1:0] nc;
  logic [SDW-1:0] wc;
  logic [SDW-1:0] hc;

  logic [XW-1:0]  col;
  logic [XW-1:0]  row;
  logic [CHW-1:0] ch;
  logic [AW-1:0]  addr;
  logic [CHW-1:0] wch;
  logic col_end, row_end, ch_end;

  logic signed [SW-1:0] acc;
  logic signed [SW-1:0] acc_sum;
  logic signed [TW-1:0] total;
  logic                 zero_flag;

  logic signed [15:0] store [DEPTH];
  logic signed [SW-1:0] sums [MAX_CHANNELS];
  logic signed [15:0] weights [MAX_CHANNELS];

  logic signed [SW-1:0] sum_q;
  logic signed [15:0]   store_q;
  logic signed [15:0]   weight_q;
  logic [CHW-1:0]       chq;
  logic                 lastq;
  logic signed [31:0]   prod;

  logic [SW-1:0]    sum_mag;
  logic [TW-1:0]    total_mag;
  logic             div_done;
  logic signed [15:0] div_q;

  logic [31:0] pmag;
  logic [30:0] rsum;
  logic [16:0] rq;

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_nc <= 7'd1;
      reg_w  <= 6'd1;
      reg_h  <= 6'd1;
    end else if (cfg_fire) begin
      case (cfg_index)
        cas_pkg::REG_NUM_CHANNELS: reg_nc <= cfg_data;
        cas_pkg::REG_MAP_WIDTH:    reg_w  <= cfg_data[5:0];
        cas_pkg::REG_MAP_HEIGHT:   reg_h  <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (reg_nc == 7'd0) nc = CNW'(1);
    else if (reg_nc > MAX_CHANNELS) nc = CNW'(MAX_CHANNELS);
    else nc = CNW'(reg_nc);
    if (reg_w == 6'd0) wc = SDW'(1);
    else if (reg_w > MAX_SIDE) wc = SDW'(MAX_SIDE);
    else wc = SDW'(reg_w);
    if (reg_h == 6'd0) hc = SDW'(1);
    else if (reg_h > MAX_SIDE) hc = SDW'(MAX_SIDE);
    else hc = SDW'(reg_h);
  end

  assign col_end = (SDW'(col) + SDW'(1) == wc);
  assign row_end = (SDW'(row) + SDW'(1) == hc);
  assign ch_end  = (CNW'(ch) + CNW'(1) == nc);

  assign sts.pos_last   = col_end && row_end && ch_end;
  assign sts.total_zero = (total == '0);
  assign sts.wch_last   = (CNW'(wch) + CNW'(1) == nc);
  assign sts.div_done   = div_done;

  // Position counters serve the load phase and then the drain phase.
  always_ff @(posedge clk) begin
    if (rst || cfg_fire || cmd.restart) begin
      col  <= '0;
      row  <= '0;
      ch   <= '0;
      addr <= '0;
    end else if (cmd.load || cmd.emit) begin
      if (col_end) begin
        col <= '0;
        if (row_end) begin
          row <= '0;
          ch  <= ch_end ? '0 : ch + CHW'(1);
        end else begin
          row <= row + XW'(1);
        end
      end else begin
        col <= col + XW'(1);
      end
      addr <= sts.pos_last ? '0 : addr + AW'(1);
    end
  end

  assign acc_sum = acc + SW'(sample);

  always_ff @(posedge clk) begin
    if (rst || cfg_fire || cmd.restart) begin
      acc   <= '0;
      total <= '0;
    end else if (cmd.load) begin
      acc   <= (col_end && row_end) ? '0 : acc_sum;
      total <= total + TW'(sample);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) zero_flag <= 1'b0;
    else if (cmd.set_zero) zero_flag <= 1'b1;
    else if (cmd.clr_zero) zero_flag <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.wch_clr) wch <= '0;
    else if (cmd.wch_inc) wch <= wch + CHW'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      store[addr] <= sample;
      if (col_end && row_end) sums[ch] <= acc_sum;
    end
    if (cmd.sum_rd) sum_q <= sums[wch];
    if (cmd.w_wr) weights[wch] <= div_q;
    if (cmd.rd_issue) begin
      store_q  <= store[addr];
      weight_q <= weights[ch];
      chq      <= ch;
      lastq    <= sts.pos_last;
    end
  end

  assign sum_mag   = sum_q[SW-1] ? SW'(-sum_q) : SW'(sum_q);
  assign total_mag = total[TW-1] ? TW'(-total) : TW'(total);

  cas_div #(
    .NUM_W(NUM_W),
    .DEN_W(TW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   ({sum_mag, {cas_pkg::WFRAC{1'b0}}}),
    .den   (total_mag),
    .neg   (sum_q[SW-1] ^ total[TW-1]),
    .done  (div_done),
    .quot  (div_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.mul) prod <= zero_flag ? 32'sd0 : store_q * weight_q;
  end

  assign pmag = prod[31] ? 32'(-prod) : 32'(prod);
  assign rsum = pmag[30:0] + 31'(8192);
  assign rq   = rsum[30:14];

  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else result_valid <= cmd.emit;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (prod[31]) scaled <= (rq > 17'd32768) ? 16'sh8000 : 16'(-rq);
      else scaled <= (rq > 17'd32767) ? 16'sh7fff : rq[15:0];
      channel    <= 6'(chq);
      zero_total <= zero_flag;
      last       <= lastq;
    end
  end

endmodule

@@ rtl/cas_ctrl.sv @@
module cas_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          op,
  input  logic          cfg_fire,
  input  cas_pkg::sts_t sts,
  output cas_pkg::cmd_t cmd,
  output logic          busy
);

  cas_pkg::state_t state, state_next;
  logic            emit_phase, emit_phase_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= cas_pkg::S_LOAD;
      emit_phase <= 1'b0;
    end else begin
      state      <= state_next;
      emit_phase <= emit_phase_next;
    end
  end

  always_comb begin
    state_next      = state;
    emit_phase_next = 1'b0;
    cmd             = '0;
    busy            = 1'b1;
    case (state)
      cas_pkg::S_LOAD: begin
        busy = 1'b0;
        if (start && !op) begin
          cmd.load = 1'b1;
          if (sts.pos_last) state_next = cas_pkg::S_CHECK;
        end
      end
      cas_pkg::S_CHECK: begin
        cmd.wch_clr = 1'b1;
        if (sts.total_zero) begin
          cmd.set_zero = 1'b1;
          state_next   = cas_pkg::S_DRAIN;
        end else begin
          cmd.clr_zero = 1'b1;
          state_next   = cas_pkg::S_RDSUM;
        end
      end
      cas_pkg::S_RDSUM: begin
        cmd.sum_rd = 1'b1;
        state_next = cas_pkg::S_DIVGO;
      end
      cas_pkg::S_DIVGO: begin
        cmd.div_start = 1'b1;
        state_next    = cas_pkg::S_DIVWAIT;
      end
      cas_pkg::S_DIVWAIT: begin
        if (sts.div_done) begin
          cmd.w_wr = 1'b1;
          if (sts.wch_last) begin
            state_next = cas_pkg::S_DRAIN;
          end else begin
            cmd.wch_inc = 1'b1;
            state_next  = cas_pkg::S_RDSUM;
          end
        end
      end
      cas_pkg::S_DRAIN: begin
        busy = 1'b0;
        if (start && op) begin
          cmd.rd_issue = 1'b1;
          state_next   = cas_pkg::S_MUL;
        end
      end
      cas_pkg::S_MUL: begin
        // With emit_phase low this state multiplies; with it high it rounds and emits the beat.
        if (!emit_phase) begin
          cmd.mul         = 1'b1;
          emit_phase_next = 1'b1;
        end else begin
          cmd.emit = 1'b1;
          if (sts.pos_last) begin
            cmd.restart = 1'b1;
            state_next  = cas_pkg::S_LOAD;
          end else begin
            state_next = cas_pkg::S_DRAIN;
          end
        end
      end
      default: begin
        state_next = cas_pkg::S_LOAD;
      end
    endcase
    if (cfg_fire) begin
      state_next      = cas_pkg::S_LOAD;
      emit_phase_next = 1'b0;
    end
  end

endmodule
